// File: src/ofr_pkg.sv
// shared constants and types for the orthonormal frame block
package ofr_pkg;

  // default component width, Q2.(width-2)
  localparam int DATA_WIDTH_DEF = 16;
  // normalized tangent magnitude word, squared word and root word
  localparam int NORM_W = 32;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;
  localparam int DIM_W  = 2;

  // dimension register codes
  typedef enum logic [DIM_W-1:0] {
    DIM_NONE = 2'd0,
    DIM_1D   = 2'd1,
    DIM_2D   = 2'd2,
    DIM_3D   = 2'd3
  } dim_e;

  localparam dim_e DIM_RESET = DIM_3D;

endpackage

// File: src/normal_to_orthonormal_frame.sv
// top level: orthonormal frame from a fixed point normal vector
//
// Usage: drive normal_x_i, normal_y_i, normal_z_i and pulse start_i; the item
// transfers at every rising edge with start_i high and busy_o low. busy_o is
// always low, so a new normal can be sent in every cycle.
// Each result shows on m00_o..m22_o and degenerate_o for exactly one cycle
// with result_valid_o high, in input order. The path runs through the 32-stage
// square root pipeline and the (DATA_WIDTH - 1)-stage divider, one result bit
// per stage, plus eight stages of selection, normalize shift, squaring,
// multiply and rounding.
// Throughput is one frame per clock.
// The dimension register is written over the cfg channel (cfg_ready_o is
// always high); write it only while no frame is in flight.
// Reset clears every valid bit in the pipeline and sets the dimension to 3.
// The receiver takes every result as it comes; there is no back pressure.
module normal_to_orthonormal_frame #(
  parameter int DATA_WIDTH = ofr_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [DATA_WIDTH-1:0]  normal_x_i,
  input  logic signed [DATA_WIDTH-1:0]  normal_y_i,
  input  logic signed [DATA_WIDTH-1:0]  normal_z_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ofr_pkg::DIM_W-1:0]     cfg_data_i,
  output logic                          result_valid_o,
  output logic signed [DATA_WIDTH-1:0]  m00_o,
  output logic signed [DATA_WIDTH-1:0]  m01_o,
  output logic signed [DATA_WIDTH-1:0]  m02_o,
  output logic signed [DATA_WIDTH-1:0]  m10_o,
  output logic signed [DATA_WIDTH-1:0]  m11_o,
  output logic signed [DATA_WIDTH-1:0]  m12_o,
  output logic signed [DATA_WIDTH-1:0]  m20_o,
  output logic signed [DATA_WIDTH-1:0]  m21_o,
  output logic signed [DATA_WIDTH-1:0]  m22_o,
  output logic                          degenerate_o
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = W - 2;
  localparam int QW   = F + 1;
  localparam int TW   = F + 2;
  localparam int NW   = ofr_pkg::NORM_W + QW;
  localparam int PW   = W + TW;
  localparam int DFW  = PW + 1;
  localparam int SH_W = $clog2(ofr_pkg::NORM_W);
  localparam int LAT  = 8 + ofr_pkg::ROOT_W + QW;

  localparam logic [W+3:0]    THR     = (W + 4)'(9) << F;
  localparam logic [SH_W-1:0] TOP_POS = SH_W'(ofr_pkg::NORM_W - 2);
  localparam logic [DFW-1:0]  HALF    = DFW'(1) << (F - 1);

  typedef struct packed {
    logic signed [W-1:0] nx;
    logic signed [W-1:0] ny;
    logic signed [W-1:0] nz;
    logic                an;
    logic                bn;
    logic                use_y;
    logic                degen;
  } vec_t;

  typedef struct packed {
    vec_t                        vec;
    logic [ofr_pkg::NORM_W-1:0] ma;
    logic [ofr_pkg::NORM_W-1:0] mb;
  } isq_side_t;

  localparam int ISQ_SIDE_W = $bits(isq_side_t);
  localparam int VEC_W      = $bits(vec_t);

  // round a full product difference back to Q2.F, halves away from zero
  function automatic logic signed [DFW:0] round_frac(input logic signed [DFW-1:0] v);
    logic [DFW-1:0] mag;
    logic [DFW-1:0] rnd;
    mag = v[DFW-1] ? DFW'(-v) : DFW'(v);
    rnd = (mag + HALF) >> F;
    return v[DFW-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
  endfunction

  // clamp to the signed output range
  function automatic logic [W-1:0] sat_w(input logic signed [DFW:0] v);
    if ((&v[DFW:W-1]) || !(|v[DFW:W-1])) begin
      return v[W-1:0];
    end else begin
      return v[DFW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // configuration register
  ofr_pkg::dim_e dim_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= ofr_pkg::DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dim_q <= ofr_pkg::dim_e'(cfg_data_i);
    end
  end

  // stage 1: magnitudes, axis choice and the two nonzero tangent components
  logic          v1_q;
  vec_t          vec1_d, vec1_q;
  logic [W-1:0]  am1_d, am1_q, bm1_d, bm1_q;
  logic [W-1:0]  nx_mag, ny_mag, nz_mag;
  logic [W+3:0]  nz_x10;

  always_comb begin
    nx_mag = normal_x_i[W-1] ? W'(-normal_x_i) : W'(normal_x_i);
    ny_mag = normal_y_i[W-1] ? W'(-normal_y_i) : W'(normal_y_i);
    nz_mag = normal_z_i[W-1] ? W'(-normal_z_i) : W'(normal_z_i);
    nz_x10 = ((W + 4)'(nz_mag) << 3) + ((W + 4)'(nz_mag) << 1);
    vec1_d.nx    = normal_x_i;
    vec1_d.ny    = normal_y_i;
    vec1_d.nz    = normal_z_i;
    vec1_d.use_y = (nz_x10 > THR);
    vec1_d.degen = 1'b0;
    // y reference: t = (-nz, 0, nx), else z reference: t = (ny, -nx, 0)
    am1_d        = vec1_d.use_y ? nz_mag : ny_mag;
    vec1_d.an    = vec1_d.use_y ? ~normal_z_i[W-1] : normal_y_i[W-1];
    bm1_d        = nx_mag;
    vec1_d.bn    = vec1_d.use_y ? normal_x_i[W-1] : ~normal_x_i[W-1];
  end

  // stage 2: largest magnitude and its leading one
  logic                       v2_q;
  vec_t                       vec2_d, vec2_q;
  logic [W-1:0]               am2_q, bm2_q;
  logic [SH_W-1:0]            k2_d, k2_q;
  logic [W-1:0]               mx;
  logic [ofr_pkg::NORM_W-1:0] mx_w;
  logic [SH_W-1:0]            msb;

  always_comb begin
    mx   = (am1_q > bm1_q) ? am1_q : bm1_q;
    mx_w = ofr_pkg::NORM_W'(mx);
    msb  = '0;
    for (int i = 0; i < ofr_pkg::NORM_W; i++) begin
      if (mx_w[i]) begin
        msb = SH_W'(i);
      end
    end
    k2_d         = (msb >= TOP_POS) ? '0 : TOP_POS - msb;
    vec2_d       = vec1_q;
    vec2_d.degen = (mx == '0);
  end

  // stage 3: normalize shift
  logic                       v3_q;
  vec_t                       vec3_q;
  logic [ofr_pkg::NORM_W-1:0] ma3_d, ma3_q, mb3_d, mb3_q;

  assign ma3_d = ofr_pkg::NORM_W'(am2_q) << k2_q;
  assign mb3_d = ofr_pkg::NORM_W'(bm2_q) << k2_q;

  // stage 4: squares
  logic                       v4_q;
  vec_t                       vec4_q;
  logic [ofr_pkg::NORM_W-1:0] ma4_q, mb4_q;
  logic [ofr_pkg::SQ_W-1:0]   sqa4_d, sqa4_q, sqb4_d, sqb4_q;

  assign sqa4_d = ma3_q * ma3_q;
  assign sqb4_d = mb3_q * mb3_q;

  // stage 5: sum of squares
  logic                     v5_q;
  isq_side_t                side5_q;
  logic [ofr_pkg::SQ_W-1:0] rad5_d, rad5_q;

  assign rad5_d = sqa4_q + sqb4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vec1_q      <= vec1_d;
    am1_q       <= am1_d;
    bm1_q       <= bm1_d;
    vec2_q      <= vec2_d;
    am2_q       <= am1_q;
    bm2_q       <= bm1_q;
    k2_q        <= k2_d;
    vec3_q      <= vec2_q;
    ma3_q       <= ma3_d;
    mb3_q       <= mb3_d;
    vec4_q      <= vec3_q;
    ma4_q       <= ma3_q;
    mb4_q       <= mb3_q;
    sqa4_q      <= sqa4_d;
    sqb4_q      <= sqb4_d;
    side5_q.vec <= vec4_q;
    side5_q.ma  <= ma4_q;
    side5_q.mb  <= mb4_q;
    rad5_q      <= rad5_d;
  end

  // square root of the sum of squares
  logic                       v_isq;
  logic [ISQ_SIDE_W-1:0]      side_isq_raw;
  isq_side_t                  side_isq;
  logic [ofr_pkg::ROOT_W-1:0] root_isq;

  ofr_isqrt #(
    .SIDE_W (ISQ_SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .rad_i   (rad5_q),
    .side_i  (side5_q),
    .valid_o (v_isq),
    .root_o  (root_isq),
    .side_o  (side_isq_raw)
  );

  assign side_isq = isq_side_t'(side_isq_raw);

  // stage 6: scaled numerators with half the divisor for rounding
  logic                       v6_q;
  vec_t                       vec6_q;
  logic [NW-1:0]              num_a6_d, num_a6_q, num_b6_d, num_b6_q;
  logic [ofr_pkg::ROOT_W-1:0] den6_q;

  assign num_a6_d = (NW'(side_isq.ma) << F) + NW'(root_isq >> 1);
  assign num_b6_d = (NW'(side_isq.mb) << F) + NW'(root_isq >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v_isq;
    end
  end

  always_ff @(posedge clk_i) begin
    vec6_q   <= side_isq.vec;
    num_a6_q <= num_a6_d;
    num_b6_q <= num_b6_d;
    den6_q   <= root_isq;
  end

  // unit tangent components
  logic             v_div;
  logic [VEC_W-1:0] vec_div_raw;
  vec_t             vec_div;
  logic [QW-1:0]    qa_div, qb_div;

  ofr_div #(
    .QW     (QW),
    .SIDE_W (VEC_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .num_a_i (num_a6_q),
    .num_b_i (num_b6_q),
    .den_i   (den6_q),
    .side_i  (vec6_q),
    .valid_o (v_div),
    .quo_a_o (qa_div),
    .quo_b_o (qb_div),
    .side_o  (vec_div_raw)
  );

  assign vec_div = vec_t'(vec_div_raw);

  // stage 7: signed tangent and cross product terms
  logic                  v7_q;
  vec_t                  vec7_q;
  logic signed [TW-1:0]  ta, tb;
  logic signed [TW-1:0]  t0_d, t0_q, t1_d, t1_q, t2_d, t2_q;
  logic signed [PW-1:0]  p_ny_t2_d, p_ny_t2_q, p_nz_t1_d, p_nz_t1_q;
  logic signed [PW-1:0]  p_nz_t0_d, p_nz_t0_q, p_nx_t2_d, p_nx_t2_q;
  logic signed [PW-1:0]  p_nx_t1_d, p_nx_t1_q, p_ny_t0_d, p_ny_t0_q;

  always_comb begin
    ta        = vec_div.an ? -$signed({1'b0, qa_div}) : $signed({1'b0, qa_div});
    tb        = vec_div.bn ? -$signed({1'b0, qb_div}) : $signed({1'b0, qb_div});
    t0_d      = ta;
    t1_d      = vec_div.use_y ? '0 : tb;
    t2_d      = vec_div.use_y ? tb : '0;
    p_ny_t2_d = $signed(vec_div.ny) * t2_d;
    p_nz_t1_d = $signed(vec_div.nz) * t1_d;
    p_nz_t0_d = $signed(vec_div.nz) * t0_d;
    p_nx_t2_d = $signed(vec_div.nx) * t2_d;
    p_nx_t1_d = $signed(vec_div.nx) * t1_d;
    p_ny_t0_d = $signed(vec_div.ny) * t0_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v_div;
    end
  end

  always_ff @(posedge clk_i) begin
    vec7_q    <= vec_div;
    t0_q      <= t0_d;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    p_ny_t2_q <= p_ny_t2_d;
    p_nz_t1_q <= p_nz_t1_d;
    p_nz_t0_q <= p_nz_t0_d;
    p_nx_t2_q <= p_nx_t2_d;
    p_nx_t1_q <= p_nx_t1_d;
    p_ny_t0_q <= p_ny_t0_d;
  end

  // stage 8: second tangent, rounding, saturation and matrix assembly
  logic signed [DFW-1:0] d6, d7, d8;
  logic [W-1:0] m00_d, m01_d, m02_d, m10_d, m11_d, m12_d, m20_d, m21_d, m22_d;
  logic [W-1:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m20_q, m21_q, m22_q;
  logic         degen_d, degen_q;
  logic         res_valid_q;

  always_comb begin
    d6 = DFW'(p_ny_t2_q) - DFW'(p_nz_t1_q);
    d7 = DFW'(p_nz_t0_q) - DFW'(p_nx_t2_q);
    d8 = DFW'(p_nx_t1_q) - DFW'(p_ny_t0_q);
    m00_d   = '0;
    m01_d   = '0;
    m02_d   = '0;
    m10_d   = '0;
    m11_d   = '0;
    m12_d   = '0;
    m20_d   = '0;
    m21_d   = '0;
    m22_d   = '0;
    degen_d = 1'b0;
    case (dim_q)
      ofr_pkg::DIM_1D: begin
        m00_d = vec7_q.nx;
      end
      ofr_pkg::DIM_2D: begin
        m00_d = vec7_q.nx;
        m01_d = vec7_q.ny;
        m10_d = sat_w((DFW + 1)'(-$signed({vec7_q.ny[W-1], vec7_q.ny})));
        m11_d = vec7_q.nx;
      end
      ofr_pkg::DIM_3D: begin
        m00_d   = vec7_q.nx;
        m01_d   = vec7_q.ny;
        m02_d   = vec7_q.nz;
        degen_d = vec7_q.degen;
        if (!vec7_q.degen) begin
          m10_d = W'(t0_q);
          m11_d = W'(t1_q);
          m12_d = W'(t2_q);
          m20_d = sat_w(round_frac(d6));
          m21_d = sat_w(round_frac(d7));
          m22_d = sat_w(round_frac(d8));
        end
      end
      default: begin
        m00_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m00_q   <= m00_d;
    m01_q   <= m01_d;
    m02_q   <= m02_d;
    m10_q   <= m10_d;
    m11_q   <= m11_d;
    m12_q   <= m12_d;
    m20_q   <= m20_d;
    m21_q   <= m21_d;
    m22_q   <= m22_d;
    degen_q <= degen_d;
  end

  assign result_valid_o = res_valid_q;
  assign m00_o          = m00_q;
  assign m01_o          = m01_q;
  assign m02_o          = m02_q;
  assign m10_o          = m10_q;
  assign m11_o          = m11_q;
  assign m12_o          = m12_q;
  assign m20_o          = m20_q;
  assign m21_o          = m21_q;
  assign m22_o          = m22_q;
  assign degenerate_o   = degen_q;

  // every start transfer yields a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT result_valid_o)
    else $error("result missing after start transfer");

  // no result appears without a matching start transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without start transfer");

  // degenerate flag only in a 3d frame
  a_degen_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |-> (dim_q == ofr_pkg::DIM_3D))
    else $error("degenerate flag outside 3d");

  // a zero-length tangent clears both tangent rows
  a_degen_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |->
      (m10_o == '0 && m11_o == '0 && m12_o == '0 &&
       m20_o == '0 && m21_o == '0 && m22_o == '0))
    else $error("tangent rows not cleared on degenerate frame");

endmodule

// File: src/ofr_isqrt.sv
// pipelined integer square root, one result bit per stage, with side payload
module ofr_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [ofr_pkg::SQ_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [ofr_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int NS = ofr_pkg::ROOT_W;
  localparam int RW = ofr_pkg::ROOT_W + 4;

  logic                      vld_q  [NS];
  logic [SIDE_W-1:0]         side_q [NS];
  logic [ofr_pkg::ROOT_W-1:0] root_q [NS];
  logic [RW-1:0]             rem_q  [NS-1];
  logic [ofr_pkg::SQ_W-1:0]  rad_q  [NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW-1:0]              rem_in;
    logic [RW-1:0]              rem_sh;
    logic [RW-1:0]              trial;
    logic [ofr_pkg::ROOT_W-1:0] root_in;
    logic [ofr_pkg::SQ_W-1:0]   rad_in;
    logic [SIDE_W-1:0]          side_in;
    logic                       vld_in;
    logic                       fit;

    // stage inputs
    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[RW-3:0], rad_in[ofr_pkg::SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign fit    = (rem_sh >= trial);

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    // root and side payload
    always_ff @(posedge clk_i) begin
      side_q[s] <= side_in;
      root_q[s] <= {root_in[ofr_pkg::ROOT_W-2:0], fit};
    end

    // partial remainder and radicand for the following stage
    if (s < NS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= fit ? (rem_sh - trial) : rem_sh;
        rad_q[s] <= {rad_in[ofr_pkg::SQ_W-3:0], 2'b00};
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// File: src/ofr_div.sv
// pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage
module ofr_div #(
  parameter int QW     = 15,
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [ofr_pkg::NORM_W+QW-1:0] num_a_i,
  input  logic [ofr_pkg::NORM_W+QW-1:0] num_b_i,
  input  logic [ofr_pkg::NORM_W-1:0]  den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [QW-1:0]               quo_a_o,
  output logic [QW-1:0]               quo_b_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int NW = ofr_pkg::NORM_W + QW;
  localparam int DW = ofr_pkg::NORM_W;

  logic [NW-1:0]     num    [2];
  logic              vld_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];
  logic [QW-1:0]     quo_q  [2][QW];
  logic [DW-1:0]     rem_q  [2][QW-1];
  logic [QW-1:0]     lo_q   [2][QW-1];
  logic [DW-1:0]     den_q  [QW-1];

  assign num[0] = num_a_i;
  assign num[1] = num_b_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0]     den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    // shared stage inputs
    if (s == 0) begin : g_first
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    // side payload
    always_ff @(posedge clk_i) begin
      side_q[s] <= side_in;
    end

    if (s < QW - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        den_q[s] <= den_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW-1:0] rem_in;
      logic [QW-1:0] lo_in;
      logic [QW-1:0] quo_in;
      logic [DW:0]   trial;
      logic          fit;

      // lane inputs, the first stage starts from the upper numerator bits
      if (s == 0) begin : g_first
        assign rem_in = num[l][NW-1:QW];
        assign lo_in  = num[l][QW-1:0];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[l][s-1];
        assign lo_in  = lo_q[l][s-1];
        assign quo_in = quo_q[l][s-1];
      end

      // shift in one numerator bit and compare against the divisor
      assign trial = {rem_in, lo_in[QW-1]};
      assign fit   = (trial >= {1'b0, den_in});

      always_ff @(posedge clk_i) begin
        quo_q[l][s] <= {quo_in[QW-2:0], fit};
      end

      if (s < QW - 1) begin : g_carry
        logic [DW:0] rem_nx;
        assign rem_nx = fit ? (trial - {1'b0, den_in}) : trial;
        always_ff @(posedge clk_i) begin
          rem_q[l][s] <= rem_nx[DW-1:0];
          lo_q[l][s]  <= {lo_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_a_o = quo_q[0][QW-1];
  assign quo_b_o = quo_q[1][QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// File: verif/normal_to_orthonormal_frame_tb.sv
// self-checking testbench for the orthonormal frame block
module normal_to_orthonormal_frame_tb;

  localparam int DW = 16;
  localparam int FB = DW - 2;
  localparam int LATENCY = 40 + DW - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;

  typedef struct {
    logic signed [DW-1:0] m [9];
    logic                 degen;
  } frame_t;

  int error_count = 0;

  // one-line mismatch report
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [DW-1:0] clamp(longint v);
    if (v > SMAX) v = SMAX;
    if (v < SMIN) v = SMIN;
    return v[DW-1:0];
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_frac(longint v);
    longint q;
    q = (mag(v) + (64'sd1 <<< (FB - 1))) >>> FB;
    return v < 0 ? -q : q;
  endfunction

  // frame prediction for one normal under the given dimension
  function automatic frame_t predict_frame(ofr_pkg::dim_e dim, longint nx, longint ny,
                                           longint nz);
    frame_t f;
    longint m [9];
    longint t [3];
    longint unsigned a [3];
    longint unsigned mx, s, r, q;
    int k;
    for (int i = 0; i < 9; i++) m[i] = 0;
    f.degen = 0;
    if (dim >= ofr_pkg::DIM_1D) m[0] = nx;
    if (dim >= ofr_pkg::DIM_2D) m[1] = ny;
    if (dim == ofr_pkg::DIM_3D) begin
      m[2] = nz;
      if (mag(nz) * 10 > (64'sd9 <<< FB)) begin
        t[0] = -nz; t[1] = 0; t[2] = nx;
      end else begin
        t[0] = ny; t[1] = -nx; t[2] = 0;
      end
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = mag(t[i]);
        if (a[i] > mx) mx = a[i];
      end
      if (mx == 0) begin
        f.degen = 1;
      end else begin
        k = 0;
        while (mx < (64'd1 << 30)) begin
          mx <<= 1;
          k++;
        end
        s = 0;
        for (int i = 0; i < 3; i++) begin
          a[i] <<= k;
          s += a[i] * a[i];
        end
        r = root_floor(s);
        for (int i = 0; i < 3; i++) begin
          q = ((a[i] << FB) + r / 2) / r;
          t[i] = t[i] < 0 ? -longint'(q) : longint'(q);
        end
        m[3] = t[0]; m[4] = t[1]; m[5] = t[2];
        m[6] = round_frac(ny * t[2] - nz * t[1]);
        m[7] = round_frac(nz * t[0] - nx * t[2]);
        m[8] = round_frac(nx * t[1] - ny * t[0]);
      end
    end else if (dim == ofr_pkg::DIM_2D) begin
      m[3] = -ny;
      m[4] = nx;
    end
    for (int i = 0; i < 9; i++) f.m[i] = clamp(m[i]);
    return f;
  endfunction

  // scoreboard of frames in flight
  class frame_scoreboard;
    frame_t pending [$];
    ofr_pkg::dim_e dim = ofr_pkg::DIM_RESET;

    function void note_normal(logic signed [DW-1:0] x, logic signed [DW-1:0] y,
                              logic signed [DW-1:0] z);
      pending.push_back(predict_frame(dim, x, y, z));
    endfunction

    task check_frame(frame_t got);
      frame_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected frame", 0, 0);
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.m[i] !== want.m[i])
          report_mismatch($sformatf("m%0d%0d", i / 3, i % 3), got.m[i], want.m[i]);
      if (got.degen !== want.degen) report_mismatch("degenerate", got.degen, want.degen);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic start = 0, cfg_valid = 0;
  logic [ofr_pkg::DIM_W-1:0] cfg_data = ofr_pkg::DIM_3D;
  logic signed [DW-1:0] nx = 0, ny = 0, nz = 0;
  logic busy, cfg_ready, res_valid, degen;
  logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  frame_scoreboard sb = new();
  int idle_cycles = 0;
  bit no_gaps = 0;

  normal_to_orthonormal_frame #(.DATA_WIDTH(DW)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .normal_x_i(nx), .normal_y_i(ny), .normal_z_i(nz),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .result_valid_o(res_valid),
    .m00_o(m00), .m01_o(m01), .m02_o(m02), .m10_o(m10), .m11_o(m11),
    .m12_o(m12), .m20_o(m20), .m21_o(m21), .m22_o(m22), .degenerate_o(degen)
  );

  // clock
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // input transfers, result checks and watchdog
  always @(posedge clk) begin
    frame_t got;
    if (rst_n) begin
      if (start && !busy) sb.note_normal(nx, ny, nz);
      if (res_valid) begin
        got.m[0] = m00; got.m[1] = m01; got.m[2] = m02;
        got.m[3] = m10; got.m[4] = m11; got.m[5] = m12;
        got.m[6] = m20; got.m[7] = m21; got.m[8] = m22;
        got.degen = degen;
        sb.check_frame(got);
      end
      if ((start && !busy) || res_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // register write while idle
  task automatic write_dimension(ofr_pkg::dim_e d);
    cfg_valid <= 1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.dim = d;
    cfg_valid <= 0;
  endtask

  // one normal transfer with an optional random gap in front
  task automatic send_normal(logic signed [DW-1:0] x, logic signed [DW-1:0] y,
                             logic signed [DW-1:0] z);
    while (!no_gaps && $urandom_range(99) < 33) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    nx <= x; ny <= y; nz <= z;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 0;
      3: return $urandom_range(14745, 14760) * ($urandom_range(1) ? 1 : -1);
      default: return $urandom;
    endcase
  endfunction

  // random normal: components within +-1.0 in Q2.14, or edge-case component values
  task automatic send_random();
    if ($urandom_range(3) == 0)
      send_normal(rand_comp(), rand_comp(), rand_comp());
    else
      send_normal($signed(DW'($urandom_range(32768) - 16384)),
                  $signed(DW'($urandom_range(32768) - 16384)),
                  $signed(DW'($urandom_range(32768) - 16384)));
  endtask

  initial begin
    ofr_pkg::dim_e dims [4] = '{ofr_pkg::DIM_3D, ofr_pkg::DIM_2D, ofr_pkg::DIM_1D,
                                ofr_pkg::DIM_NONE};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, threshold edges, degenerate tangents
    send_normal(0, 0, 0);
    send_normal(16384, 0, 0);
    send_normal(0, 16384, 0);
    send_normal(0, 0, 16384);
    send_normal(0, 0, 14746);
    send_normal(0, 0, 14745);
    send_normal(0, 0, -14746);
    send_normal(16'sh8000, 16'sh8000, 16'sh8000);
    send_normal(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_normal(16'sh7fff, 16'sh8000, 0);
    send_normal(1, -1, 1);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_dimension(dims[p]);
      send_normal(16'sh8000, 16'sh8000, 16'sh7fff);
      send_normal(16'sh7fff, 16'sh7fff, 16'sh8000);
      send_normal(0, 0, 0);
      drain();
    end
    // random phases, the first four in 3d, the rest under randomly chosen settings
    for (int p = 0; p < 8; p++) begin
      write_dimension(p < 4 ? ofr_pkg::DIM_3D : dims[$urandom_range(3)]);
      no_gaps = (p == 2);
      repeat (115) send_random();
      drain();
    end
    write_dimension(ofr_pkg::DIM_3D);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
